/* src/rtpl_pkg.sv */
// Shared types and codes for the routing table lookup block.
// No dependencies; used by rtpl_seq, the top level and the testbench.
`default_nettype none

package rtpl_pkg;

    localparam int ADDR_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;

    // Command codes of an input item.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE0_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE0_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE1_ADDR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE1_MASK = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] route_mask;
        logic [ADDR_W-1:0] route_net;
        logic [ADDR_W-1:0] route_next_hop;
        logic [POS_W-1:0]  position;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   hop_addr;
        logic                is_direct;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] iface0_addr;
        logic [ADDR_W-1:0] iface0_mask;
        logic [ADDR_W-1:0] iface1_addr;
        logic [ADDR_W-1:0] iface1_mask;
    } iface_cfg_t;

    // One static route as held in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] next_hop;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_READ,
        ST_LK_CMP,
        ST_ADD_READ,
        ST_ADD_CMP,
        ST_DEL_READ,
        ST_DEL_WRITE,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

/* src/rtpl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rtpl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/rtpl_seq.sv */
// Command sequencer: walks the static route memory for lookup, insert and delete.
// Depends on rtpl_pkg and rtpl_ram.
`default_nettype none

module rtpl_seq #(
    parameter int STATIC_ENTRIES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire rtpl_pkg::req_item_t req,
    input  wire rtpl_pkg::iface_cfg_t cfg,
    input  wire logic               out_free,
    output logic                    res_valid,
    output rtpl_pkg::rsp_item_t     res
);

    localparam int IW = (STATIC_ENTRIES > 1) ? $clog2(STATIC_ENTRIES) : 1;
    localparam int CW = $clog2(STATIC_ENTRIES + 1);
    localparam int PW = ((CW > rtpl_pkg::POS_W) ? CW : rtpl_pkg::POS_W) + 1;

    rtpl_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    rtpl_pkg::req_item_t   op_reg, op_next;
    rtpl_pkg::rsp_item_t   res_reg, res_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    rtpl_pkg::route_entry_t ram_wdata;
    logic                   ram_re;
    logic [IW-1:0]          ram_raddr;
    rtpl_pkg::route_entry_t ram_rdata;
    rtpl_pkg::route_entry_t new_entry;

    logic          req_fire;
    logic          direct_hit;
    logic          table_full;
    logic [PW-1:0] pos_ext;
    logic          del_refused;
    logic          del_range;
    logic [CW:0]   idx_inc;
    logic          lk_more;
    logic          lk_hit;
    logic          add_at_top;
    logic          add_place;
    logic          del_more;

    rtpl_ram #(
        .WIDTH (rtpl_pkg::ENTRY_W),
        .DEPTH (STATIC_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != rtpl_pkg::ST_IDLE);
    assign req_fire  = req_valid && (state_reg == rtpl_pkg::ST_IDLE);
    assign res       = res_reg;

    assign new_entry = '{mask: op_reg.route_mask, net: op_reg.route_net,
                         next_hop: op_reg.route_next_hop};

    assign direct_hit =
        ((req.dest_addr & cfg.iface0_mask) == (cfg.iface0_addr & cfg.iface0_mask)) ||
        ((req.dest_addr & cfg.iface1_mask) == (cfg.iface1_addr & cfg.iface1_mask));
    assign table_full  = (count_reg >= CW'(STATIC_ENTRIES));
    assign pos_ext     = PW'(req.position);
    assign del_refused = (pos_ext < PW'(2));
    assign del_range   = (pos_ext >= (PW'(count_reg) + PW'(2)));

    assign idx_inc    = {1'b0, idx_reg} + (CW + 1)'(1);
    assign lk_more    = (idx_reg < count_reg);
    assign lk_hit     = ((op_reg.dest_addr & ram_rdata.mask) == ram_rdata.net);
    assign add_at_top = (idx_reg == '0);
    assign add_place  = (ram_rdata.mask > op_reg.route_mask);
    assign del_more   = (idx_inc < {1'b0, count_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtpl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.command)
                        rtpl_pkg::CMD_LOOKUP:
                            state_next = direct_hit ? rtpl_pkg::ST_FINISH
                                                    : rtpl_pkg::ST_LK_READ;
                        rtpl_pkg::CMD_ADD:
                            state_next = table_full ? rtpl_pkg::ST_FINISH
                                                    : rtpl_pkg::ST_ADD_READ;
                        rtpl_pkg::CMD_DELETE:
                            state_next = (del_refused || del_range) ? rtpl_pkg::ST_FINISH
                                                                    : rtpl_pkg::ST_DEL_READ;
                        default:
                            state_next = rtpl_pkg::ST_FINISH;
                    endcase
                end
            end
            rtpl_pkg::ST_LK_READ:
                state_next = lk_more ? rtpl_pkg::ST_LK_CMP : rtpl_pkg::ST_FINISH;
            rtpl_pkg::ST_LK_CMP:
                state_next = lk_hit ? rtpl_pkg::ST_FINISH : rtpl_pkg::ST_LK_READ;
            rtpl_pkg::ST_ADD_READ:
                state_next = add_at_top ? rtpl_pkg::ST_FINISH : rtpl_pkg::ST_ADD_CMP;
            rtpl_pkg::ST_ADD_CMP:
                state_next = add_place ? rtpl_pkg::ST_FINISH : rtpl_pkg::ST_ADD_READ;
            rtpl_pkg::ST_DEL_READ:
                state_next = del_more ? rtpl_pkg::ST_DEL_WRITE : rtpl_pkg::ST_FINISH;
            rtpl_pkg::ST_DEL_WRITE:
                state_next = rtpl_pkg::ST_DEL_READ;
            rtpl_pkg::ST_FINISH:
                state_next = out_free ? rtpl_pkg::ST_IDLE : rtpl_pkg::ST_FINISH;
            default:
                state_next = rtpl_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[IW-1:0];
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[IW-1:0];
        res_valid  = 1'b0;
        case (state_reg)
            rtpl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req;
                    res_next = '{status: rtpl_pkg::ST_OK, hop_addr: '0, is_direct: 1'b0};
                    case (req.command)
                        rtpl_pkg::CMD_LOOKUP:
                        begin
                            idx_next = '0;
                            if (direct_hit)
                            begin
                                res_next.hop_addr  = req.dest_addr;
                                res_next.is_direct = 1'b1;
                            end
                        end
                        rtpl_pkg::CMD_ADD:
                        begin
                            // The insert walks down from the current end of the table.
                            idx_next = count_reg;
                            if (table_full)
                            begin
                                res_next.status = rtpl_pkg::ST_FULL;
                            end
                        end
                        rtpl_pkg::CMD_DELETE:
                        begin
                            idx_next = CW'(pos_ext - PW'(2));
                            if (del_refused)
                            begin
                                res_next.status = rtpl_pkg::ST_REFUSED;
                            end
                            else if (del_range)
                            begin
                                res_next.status = rtpl_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rtpl_pkg::ST_LK_READ:
            begin
                if (lk_more)
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    res_next.status = rtpl_pkg::ST_NO_ROUTE;
                end
            end
            rtpl_pkg::ST_LK_CMP:
            begin
                if (lk_hit)
                begin
                    res_next.hop_addr = ram_rdata.next_hop;
                end
                else
                begin
                    idx_next = idx_inc[CW-1:0];
                end
            end
            rtpl_pkg::ST_ADD_READ:
            begin
                if (add_at_top)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = new_entry;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(idx_reg - CW'(1));
                end
            end
            rtpl_pkg::ST_ADD_CMP:
            begin
                // Either the new route lands here, or the older entry moves up one.
                ram_we = 1'b1;
                if (add_place)
                begin
                    ram_wdata = new_entry;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                end
            end
            rtpl_pkg::ST_DEL_READ:
            begin
                if (del_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[IW-1:0];
                end
            end
            rtpl_pkg::ST_DEL_WRITE:
            begin
                ram_we   = 1'b1;
                idx_next = idx_inc[CW-1:0];
            end
            rtpl_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid = 1'b1;
                    if (res_reg.status == rtpl_pkg::ST_OK)
                    begin
                        if (op_reg.command == rtpl_pkg::CMD_ADD)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else if (op_reg.command == rtpl_pkg::CMD_DELETE)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtpl_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STATIC_ENTRIES))
        else $error("static route count exceeds table size");

    a_count_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |=> $stable(count_reg))
        else $error("route count changed without a result");

    a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtpl_pkg::ST_LK_READ || state_reg == rtpl_pkg::ST_LK_CMP) |-> !ram_we)
        else $error("table written during a lookup");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != rtpl_pkg::ST_IDLE))
        else $error("sequencer stayed idle after taking an item");

    a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued while output register is occupied");

endmodule

`default_nettype wire

/* src/route_table_prefix_lookup.sv */
// Top level of the routing table: interface configuration, sequencer and result register.
// Depends on rtpl_pkg, rtpl_seq and rtpl_ram.
//
// Usage: commands arrive on the req channel (req_valid / req_stall / req) and each
// produces exactly one result on the rsp channel (rsp_valid / rsp_stall / rsp).
// The two interface networks are set through cfg_we / cfg_index / cfg_data while idle;
// that is for the user to keep, as the block itself does not enforce it.
// Static routes live in a table memory with one read port and a registered read, and the
// sequencer handles each entry it touches in a read state, then a compare/write state.
// A direct-hit lookup, an invalid command and a rejected add or delete go straight to
// the finish state; other commands walk the table entry by entry.
// One item is processed at a time; req_stall is high while an item is in progress.
// A finished result sits in the output register while the next item is taken.
// If rsp_stall holds that register, the sequencer waits with its next result.
// Reset clears the configuration to zero and empties the static route table.
`default_nettype none

module route_table_prefix_lookup #(
    parameter int STATIC_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire rtpl_pkg::req_item_t              req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output rtpl_pkg::rsp_item_t                   rsp,
    input  wire logic                             cfg_we,
    input  wire logic [rtpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rtpl_pkg::ADDR_W-1:0]      cfg_data
);

    rtpl_pkg::iface_cfg_t cfg_reg;
    logic                 rsp_valid_reg;
    rtpl_pkg::rsp_item_t  rsp_reg;
    logic                 out_free;
    logic                 res_valid;
    rtpl_pkg::rsp_item_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtpl_pkg::CFG_IFACE0_ADDR: cfg_reg.iface0_addr <= cfg_data;
                rtpl_pkg::CFG_IFACE0_MASK: cfg_reg.iface0_mask <= cfg_data;
                rtpl_pkg::CFG_IFACE1_ADDR: cfg_reg.iface1_addr <= cfg_data;
                rtpl_pkg::CFG_IFACE1_MASK: cfg_reg.iface1_mask <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rtpl_seq #(
        .STATIC_ENTRIES (STATIC_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* bench/route_table_prefix_lookup_tb.sv */
// Self-checking testbench for the route_table_prefix_lookup routing table.
// Depends on rtpl_pkg and the route_table_prefix_lookup RTL. It keeps its own copy
// of the route table, predicts every result and checks it, under random flow control.
`default_nettype none

module route_table_prefix_lookup_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 4 + 2 * TABLE_DEPTH + 6;
    // The spare command code, which the block answers without touching the table.
    localparam logic [rtpl_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    rtpl_pkg::req_item_t req;
    logic rsp_valid;
    logic rsp_stall;
    rtpl_pkg::rsp_item_t rsp;
    logic cfg_we;
    logic [rtpl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rtpl_pkg::ADDR_W-1:0] cfg_data;

    // Shadow copy of the interface networks and the static routes.
    logic [rtpl_pkg::ADDR_W-1:0] if0_addr, if0_mask, if1_addr, if1_mask;
    logic [rtpl_pkg::ADDR_W-1:0] rt_mask [TABLE_DEPTH];
    logic [rtpl_pkg::ADDR_W-1:0] rt_net [TABLE_DEPTH];
    logic [rtpl_pkg::ADDR_W-1:0] rt_hop [TABLE_DEPTH];
    int rt_count;

    rtpl_pkg::rsp_item_t pending_answers [$];
    rtpl_pkg::rsp_item_t want;
    int errors = 0;
    int cycle_count = 0;
    bit bursts_on = 1'b1;
    bit hold_rsp_req = 1'b0;

    route_table_prefix_lookup #(.STATIC_ENTRIES(TABLE_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("route_table_prefix_lookup_tb NOT OK");
            $finish;
        end
    end

    // Applies one command to the shadow table and returns the answer it must give.
    function automatic rtpl_pkg::rsp_item_t route_table_apply(input rtpl_pkg::req_item_t item);
        rtpl_pkg::rsp_item_t ans;
        int slot;
        int k;
        int j;
        logic [rtpl_pkg::ADDR_W-1:0] d;
        ans.status = rtpl_pkg::ST_OK;
        ans.hop_addr = '0;
        ans.is_direct = 1'b0;
        d = item.dest_addr;
        case (item.command)
            rtpl_pkg::CMD_LOOKUP:
            begin
                if ((d & if0_mask) == (if0_addr & if0_mask)
                    || (d & if1_mask) == (if1_addr & if1_mask))
                begin
                    ans.hop_addr = d;
                    ans.is_direct = 1'b1;
                end
                else
                begin
                    ans.status = rtpl_pkg::ST_NO_ROUTE;
                    for (j = 0; j < rt_count; j++)
                    begin
                        if ((d & rt_mask[j]) == rt_net[j])
                        begin
                            ans.status = rtpl_pkg::ST_OK;
                            ans.hop_addr = rt_hop[j];
                            break;
                        end
                    end
                end
            end
            rtpl_pkg::CMD_ADD:
            begin
                if (rt_count >= TABLE_DEPTH)
                    ans.status = rtpl_pkg::ST_FULL;
                else
                begin
                    // Longer masks first; a new route goes ahead of equal masks.
                    slot = 0;
                    while (slot < rt_count && rt_mask[slot] > item.route_mask)
                        slot++;
                    for (j = rt_count; j > slot; j--)
                    begin
                        rt_mask[j] = rt_mask[j - 1];
                        rt_net[j] = rt_net[j - 1];
                        rt_hop[j] = rt_hop[j - 1];
                    end
                    rt_mask[slot] = item.route_mask;
                    rt_net[slot] = item.route_net;
                    rt_hop[slot] = item.route_next_hop;
                    rt_count++;
                end
            end
            rtpl_pkg::CMD_DELETE:
            begin
                k = int'(item.position) - 2;
                if (item.position < 2)
                    ans.status = rtpl_pkg::ST_REFUSED;
                else if (k >= rt_count)
                    ans.status = rtpl_pkg::ST_RANGE;
                else
                begin
                    for (j = k; j + 1 < rt_count; j++)
                    begin
                        rt_mask[j] = rt_mask[j + 1];
                        rt_net[j] = rt_net[j + 1];
                        rt_hop[j] = rt_hop[j + 1];
                    end
                    rt_count--;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic rtpl_pkg::req_item_t req_of(input logic [rtpl_pkg::CMD_W-1:0] cmd,
                                                   input logic [rtpl_pkg::ADDR_W-1:0] dest,
                                                   input logic [rtpl_pkg::ADDR_W-1:0] mask,
                                                   input logic [rtpl_pkg::ADDR_W-1:0] net,
                                                   input logic [rtpl_pkg::ADDR_W-1:0] hop,
                                                   input logic [rtpl_pkg::POS_W-1:0] pos);
        rtpl_pkg::req_item_t it;
        it.command = cmd;
        it.dest_addr = dest;
        it.route_mask = mask;
        it.route_net = net;
        it.route_next_hop = hop;
        it.position = pos;
        return it;
    endfunction

    function automatic logic [rtpl_pkg::ADDR_W-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : ~32'h0 << (32 - len);
    endfunction

    // An add command; most routes have a prefix mask and a network already masked.
    function automatic rtpl_pkg::req_item_t random_route();
        logic [rtpl_pkg::ADDR_W-1:0] m;
        logic [rtpl_pkg::ADDR_W-1:0] n;
        m = ($urandom_range(0, 4) != 0) ? prefix_mask($urandom_range(0, 32)) : $urandom();
        n = $urandom();
        if ($urandom_range(0, 6) != 0)
            n = n & m;
        return req_of(rtpl_pkg::CMD_ADD, $urandom(), m, n, $urandom(),
                      rtpl_pkg::POS_W'($urandom_range(0, 31)));
    endfunction

    function automatic rtpl_pkg::req_item_t random_request();
        rtpl_pkg::req_item_t it;
        int pick;
        int r;
        int i;
        logic [rtpl_pkg::ADDR_W-1:0] noise;
        it = req_of(rtpl_pkg::CMD_LOOKUP, $urandom(), $urandom(), $urandom(), $urandom(),
                    rtpl_pkg::POS_W'($urandom_range(0, 31)));
        noise = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 4)
            it.command = CMD_NOP;
        else if (pick < 50)
        begin
            // Aim most lookups at a known route or an interface network.
            r = $urandom_range(0, 9);
            if (r < 5 && rt_count > 0)
            begin
                i = $urandom_range(0, rt_count - 1);
                it.dest_addr = (rt_net[i] & rt_mask[i]) | (noise & ~rt_mask[i]);
            end
            else if (r < 6)
                it.dest_addr = (if0_addr & if0_mask) | (noise & ~if0_mask);
            else if (r < 7)
                it.dest_addr = (if1_addr & if1_mask) | (noise & ~if1_mask);
        end
        else if (pick < ((rt_count < 8) ? 82 : 72))
            it = random_route();
        else
        begin
            it.command = rtpl_pkg::CMD_DELETE;
            if ($urandom_range(0, 4) != 0 && rt_count > 0)
                it.position = rtpl_pkg::POS_W'($urandom_range(2, rt_count + 1));
        end
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input rtpl_pkg::req_item_t item);
        int gap;
        gap = 0;
        if (bursts_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        pending_answers.push_back(route_table_apply(item));
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [rtpl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtpl_pkg::ADDR_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            rtpl_pkg::CFG_IFACE0_ADDR: if0_addr = val;
            rtpl_pkg::CFG_IFACE0_MASK: if0_mask = val;
            rtpl_pkg::CFG_IFACE1_ADDR: if1_addr = val;
            rtpl_pkg::CFG_IFACE1_MASK: if1_mask = val;
            default: ;
        endcase
    endtask

    // Only called with nothing in flight.
    task automatic load_ifaces(input logic [rtpl_pkg::ADDR_W-1:0] a0,
                               input logic [rtpl_pkg::ADDR_W-1:0] m0,
                               input logic [rtpl_pkg::ADDR_W-1:0] a1,
                               input logic [rtpl_pkg::ADDR_W-1:0] m1);
        cfg_put(rtpl_pkg::CFG_IFACE0_ADDR, a0);
        cfg_put(rtpl_pkg::CFG_IFACE0_MASK, m0);
        cfg_put(rtpl_pkg::CFG_IFACE1_ADDR, a1);
        cfg_put(rtpl_pkg::CFG_IFACE1_MASK, m1);
        cfg_we <= 1'b0;
    endtask

    // With both interfaces zeroed every address is directly connected.
    task automatic test_reset_state();
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'h0000_0000, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd2));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd0));
        wait_all_answered();
    endtask

    task automatic test_directed();
        load_ifaces(32'hC0A8_0101, 32'hFFFF_FF00, 32'h0A00_0001, 32'hFF00_0000);
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hC0A8_01FF, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'h0A12_3456, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'h0000_0000, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'hFFFF_0000, 32'hAC10_0000,
                         32'hC0A8_0102, '0));
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, '0));
        // Same mask as an earlier route, so it lands ahead of it.
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'hFFFF_0000, 32'hAC11_0000,
                         32'h0A00_0002, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hAC10_ABCD, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hAC11_0001, '0, '0, '0, '0));
        // A network with bits outside its mask can never match.
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'hFFFF_FF00, 32'h0B0B_0B0B,
                         32'h0000_0001, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'h0B0B_0B0B, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd0));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd1));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd31));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd6));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd2));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'h0000_0000, 32'h0000_0000,
                         32'h1234_5678, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'h0000_0000, '0, '0, '0, '0));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hC0A8_0100, '0, '0, '0, '0));
        send_item(req_of(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 5'd31));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd5));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd2));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, 32'hAC10_0001, '0, '0, '0, '0));
        wait_all_answered();
    endtask

    task automatic test_table_full();
        while (rt_count < TABLE_DEPTH)
            send_item(random_route());
        send_item(random_route());
        send_item(req_of(rtpl_pkg::CMD_ADD, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0));
        repeat (10) send_item(random_request());
        while (rt_count > 0)
            send_item(req_of(rtpl_pkg::CMD_DELETE, $urandom(), '0, '0, '0,
                             rtpl_pkg::POS_W'($urandom_range(2, rt_count + 1))));
        send_item(req_of(rtpl_pkg::CMD_DELETE, '0, '0, '0, '0, 5'd2));
        send_item(req_of(rtpl_pkg::CMD_LOOKUP, $urandom(), '0, '0, '0, '0));
    endtask

    task automatic test_output_backpressure();
        repeat (6) send_item(random_route());
        hold_rsp_req = 1'b1;
        repeat (10) send_item(random_request());
        wait_all_answered();
    endtask

    task automatic test_random_prefix_ifaces();
        load_ifaces($urandom(), prefix_mask($urandom_range(8, 30)),
                    $urandom(), prefix_mask($urandom_range(8, 30)));
        repeat (300) send_item(random_request());
        wait_all_answered();
    endtask

    task automatic test_host_ifaces();
        load_ifaces(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        repeat (250) send_item(random_request());
        wait_all_answered();
    endtask

    // Second interface with an empty mask takes everything the first one misses.
    task automatic test_catchall_iface();
        load_ifaces($urandom(), prefix_mask($urandom_range(1, 31)), $urandom(), '0);
        repeat (60) send_item(random_request());
        wait_all_answered();
    endtask

    task automatic test_odd_masks();
        load_ifaces($urandom(), $urandom(), $urandom(), $urandom());
        repeat (300) send_item(random_request());
        wait_all_answered();
    endtask

    task automatic test_steady_flow();
        bursts_on = 1'b0;
        load_ifaces($urandom(), prefix_mask($urandom_range(16, 28)),
                    $urandom(), prefix_mask($urandom_range(4, 12)));
        repeat (300) send_item(random_request());
        wait_all_answered();
    endtask

    // Result side flow control: short random stalls, and one long hold on request.
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_rsp_req = 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d hop %h direct %b",
                         $time, rsp.status, rsp.hop_addr, rsp.is_direct);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.status !== want.status || rsp.hop_addr !== want.hop_addr
                    || rsp.is_direct !== want.is_direct)
                begin
                    errors++;
                    $display("%0t: expected status %0d hop %h direct %b, got %0d %h %b",
                             $time, want.status, want.hop_addr, want.is_direct,
                             rsp.status, rsp.hop_addr, rsp.is_direct);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = rtpl_pkg::CFG_IFACE0_ADDR;
        cfg_data = '0;
        if0_addr = '0;
        if0_mask = '0;
        if1_addr = '0;
        if1_mask = '0;
        rt_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_table_full();
        test_output_backpressure();
        test_random_prefix_ifaces();
        test_host_ifaces();
        test_catchall_iface();
        test_odd_masks();
        test_steady_flow();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("route_table_prefix_lookup_tb OK");
        else
            $display("route_table_prefix_lookup_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/rtpl_pkg.sv
src/rtpl_ram.sv
src/rtpl_seq.sv
src/route_table_prefix_lookup.sv
bench/route_table_prefix_lookup_tb.sv
